// ----- sv/i2p_pkg.sv -----
package i2p_pkg;

  // Operator stack geometry.
  localparam int STACK_DEPTH = 16;
  localparam int PtrW        = $clog2(STACK_DEPTH);
  localparam int CntW        = $clog2(STACK_DEPTH + 1);
  localparam int CharW       = 8;

  // Recognized characters.
  localparam logic [CharW-1:0] CH_MUL   = 8'h2A;
  localparam logic [CharW-1:0] CH_DIV   = 8'h2F;
  localparam logic [CharW-1:0] CH_ADD   = 8'h2B;
  localparam logic [CharW-1:0] CH_SUB   = 8'h2D;
  localparam logic [CharW-1:0] CH_OPEN  = 8'h28;
  localparam logic [CharW-1:0] CH_CLOSE = 8'h29;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_OPEN_LEFT = 2'd3;
  localparam logic [1:0] STATUS_NO_OPEN   = 2'd2;

  // Operator ranks.
  localparam logic [1:0] RANK_NONE = 2'd0;
  localparam logic [1:0] RANK_ADD  = 2'd1;
  localparam logic [1:0] RANK_MUL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROC,
    ST_FLUSH,
    ST_FINISH
  } state_e;

  // One result without its run markers.
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             valid;
    logic [1:0]       status;
  } res_t;

  // Load request for the output register.
  typedef struct packed {
    logic load;
    res_t res;
    logic last;
    logic done;
  } out_load_t;

  // Stack command from the sequencer.
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [CharW-1:0] data;
  } stk_cmd_t;

  // Stack status seen by the sequencer.
  typedef struct packed {
    logic             empty;
    logic             full;
    logic [CharW-1:0] top;
  } stk_stat_t;

  function automatic logic [1:0] rank_of(logic [CharW-1:0] c);
    logic [1:0] r;
    if (c == CH_MUL || c == CH_DIV) begin
      r = RANK_MUL;
    end else if (c == CH_ADD || c == CH_SUB) begin
      r = RANK_ADD;
    end else begin
      r = RANK_NONE;
    end
    return r;
  endfunction

endpackage

// ----- sv/infix_to_postfix_converter.sv -----
// Infix to postfix converter (shunting yard). Each accepted transfer carries one
// ASCII character; operands come out unchanged, the operators + - * / and the
// parentheses go through an operator stack of i2p_pkg::STACK_DEPTH entries held
// in a synchronous RAM with one write port and one registered read port. The
// sequencer makes at most one stack access per cycle. An end-of-expression
// character flushes every stacked entry, then finds the stack empty. A result
// that cannot move on because the output register is held by the receiver
// stalls the sequencer.
// Results carry last_of_run on the final result of each character and expr_done
// on the final result of an expression. No clearing pass is needed after reset.
module infix_to_postfix_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       end_of_expr_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       char_valid_o,
  output logic [1:0] status_o,
  output logic       last_of_run_o,
  output logic       expr_done_o
);

  i2p_pkg::stk_cmd_t  cmd;
  i2p_pkg::stk_stat_t stat;
  i2p_pkg::out_load_t out_load;
  logic               out_free;
  logic               out_valid_q;
  i2p_pkg::res_t      out_res_q;
  logic               out_last_q, out_done_q;

  i2p_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  i2p_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_char_i     (in_char_i),
    .end_of_expr_i (end_of_expr_i),
    .out_free_i    (out_free),
    .out_load_o    (out_load),
    .cmd_o         (cmd),
    .stat_i        (stat)
  );

  // Output register: free when empty or being transferred this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load.load) begin
      out_res_q  <= out_load.res;
      out_last_q <= out_load.last;
      out_done_q <= out_load.done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_res_q.ch;
  assign char_valid_o  = out_res_q.valid;
  assign status_o      = out_res_q.status;
  assign last_of_run_o = out_last_q;
  assign expr_done_o   = out_done_q;

endmodule

// ----- sv/i2p_ram.sv -----
module i2p_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/i2p_stack.sv -----
module i2p_stack (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  i2p_pkg::stk_cmd_t  cmd_i,
  output i2p_pkg::stk_stat_t stat_o
);

  logic [i2p_pkg::CntW-1:0]  count_q, count_d;
  logic [i2p_pkg::CntW-1:0]  count_m1;
  logic [i2p_pkg::PtrW-1:0]  waddr, raddr;
  logic                      we;
  logic [i2p_pkg::CharW-1:0] rdata;
  logic                      fwd_q, fwd_d;
  logic [i2p_pkg::CharW-1:0] fwd_data_q;
  logic                      empty, full;

  assign empty = (count_q == '0);
  assign full  = (count_q == i2p_pkg::CntW'(i2p_pkg::STACK_DEPTH));

  // Count update; the sequencer never pushes and pops in the same cycle.
  always_comb begin
    count_d = count_q;
    if (cmd_i.push && !full) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.pop && !empty) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      fwd_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      fwd_q   <= fwd_d;
    end
  end

  // The read port always points at the top of the next cycle's stack.
  assign count_m1 = count_d - 1'b1;
  assign raddr    = (count_d == '0) ? '0 : count_m1[i2p_pkg::PtrW-1:0];
  assign waddr    = count_q[i2p_pkg::PtrW-1:0];
  assign we       = cmd_i.push && !full;

  // A push writes the entry that is read in the same cycle, so forward it.
  assign fwd_d = we && (waddr == raddr);

  always_ff @(posedge clk_i) begin
    fwd_data_q <= cmd_i.data;
  end

  i2p_ram #(
    .Width (i2p_pkg::CharW),
    .Depth (i2p_pkg::STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (cmd_i.data),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign stat_o.empty = empty;
  assign stat_o.full  = full;
  assign stat_o.top   = fwd_q ? fwd_data_q : rdata;

endmodule

// ----- sv/i2p_ctrl.sv -----
module i2p_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [i2p_pkg::CharW-1:0] in_char_i,
  input  logic                      end_of_expr_i,
  input  logic                      out_free_i,
  output i2p_pkg::out_load_t        out_load_o,
  output i2p_pkg::stk_cmd_t         cmd_o,
  input  i2p_pkg::stk_stat_t        stat_i
);

  i2p_pkg::state_e state_q, state_d;

  logic [i2p_pkg::CharW-1:0] char_q;
  logic                      end_q;
  i2p_pkg::res_t             pend_q;
  logic                      pend_valid_q;

  logic                      can_emit, emit_req, fire;
  i2p_pkg::res_t             emit_res;
  logic                      proc_done, flush_done, fin_send, fin_ok;
  logic                      in_fire;
  logic [1:0]                char_rank;
  logic                      pop_top;

  // A new result fits when the pending slot is empty or can move on.
  assign can_emit  = !pend_valid_q || out_free_i;
  assign fire      = emit_req && can_emit;
  assign char_rank = i2p_pkg::rank_of(char_q);
  assign pop_top   = !stat_i.empty && (stat_i.top != i2p_pkg::CH_OPEN) &&
                     (i2p_pkg::rank_of(stat_i.top) >= char_rank);

  // The held result is released last, with its run markers set.
  assign fin_send = pend_valid_q || end_q;
  assign fin_ok   = (state_q == i2p_pkg::ST_FINISH) && (!fin_send || out_free_i);

  assign in_ready_o = (state_q == i2p_pkg::ST_IDLE) || fin_ok;
  assign in_fire    = in_valid_i && in_ready_o;

  // Sequencer outputs: at most one stack access and at most one result per cycle.
  always_comb begin
    emit_req   = 1'b0;
    emit_res   = '0;
    cmd_o      = '0;
    cmd_o.data = char_q;
    proc_done  = 1'b0;
    flush_done = 1'b0;
    unique case (state_q)
      i2p_pkg::ST_PROC: begin
        if (char_q == i2p_pkg::CH_CLOSE) begin
          if (stat_i.empty) begin
            emit_req        = 1'b1;
            emit_res.status = i2p_pkg::STATUS_NO_OPEN;
            proc_done       = can_emit;
          end else if (stat_i.top == i2p_pkg::CH_OPEN) begin
            cmd_o.pop = 1'b1;
            proc_done = 1'b1;
          end else begin
            emit_req       = 1'b1;
            emit_res.ch    = stat_i.top;
            emit_res.valid = 1'b1;
            cmd_o.pop      = can_emit;
          end
        end else if (char_rank != i2p_pkg::RANK_NONE && pop_top) begin
          emit_req       = 1'b1;
          emit_res.ch    = stat_i.top;
          emit_res.valid = 1'b1;
          cmd_o.pop      = can_emit;
        end else if (char_rank != i2p_pkg::RANK_NONE || char_q == i2p_pkg::CH_OPEN) begin
          if (stat_i.full) begin
            emit_req        = 1'b1;
            emit_res.status = i2p_pkg::STATUS_OVERFLOW;
            proc_done       = can_emit;
          end else begin
            cmd_o.push = 1'b1;
            proc_done  = 1'b1;
          end
        end else begin
          emit_req       = 1'b1;
          emit_res.ch    = char_q;
          emit_res.valid = 1'b1;
          proc_done      = can_emit;
        end
      end
      i2p_pkg::ST_FLUSH: begin
        if (stat_i.empty) begin
          flush_done = 1'b1;
        end else begin
          emit_req = 1'b1;
          if (stat_i.top == i2p_pkg::CH_OPEN) begin
            emit_res.status = i2p_pkg::STATUS_OPEN_LEFT;
          end else begin
            emit_res.ch    = stat_i.top;
            emit_res.valid = 1'b1;
          end
          cmd_o.pop = can_emit;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      i2p_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = i2p_pkg::ST_PROC;
        end
      end
      i2p_pkg::ST_PROC: begin
        if (proc_done) begin
          state_d = end_q ? i2p_pkg::ST_FLUSH : i2p_pkg::ST_FINISH;
        end
      end
      i2p_pkg::ST_FLUSH: begin
        if (flush_done) begin
          state_d = i2p_pkg::ST_FINISH;
        end
      end
      i2p_pkg::ST_FINISH: begin
        if (fin_ok) begin
          state_d = in_fire ? i2p_pkg::ST_PROC : i2p_pkg::ST_IDLE;
        end
      end
      default: state_d = i2p_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= i2p_pkg::ST_IDLE;
      pend_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        pend_valid_q <= 1'b1;
      end else if (fin_ok) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  // Input character and pending result.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      char_q <= in_char_i;
      end_q  <= end_of_expr_i;
    end
    if (fire) begin
      pend_q <= emit_res;
    end
  end

  // Output register load: a displaced pending result, or the run's last one.
  always_comb begin
    out_load_o = '0;
    if (fire && pend_valid_q) begin
      out_load_o.load = 1'b1;
      out_load_o.res  = pend_q;
    end else if (fin_ok && fin_send) begin
      out_load_o.load = 1'b1;
      out_load_o.res  = pend_valid_q ? pend_q : '0;
      out_load_o.last = 1'b1;
      out_load_o.done = end_q;
    end
  end

endmodule

// ----- sv/i2p_checker.sv -----
module i2p_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_char_o,
  input logic       char_valid_o,
  input logic [1:0] status_o,
  input logic       last_of_run_o,
  input logic       expr_done_o
);

  // A stalled result holds until it is transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o) &&
    $stable(status_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  // A status-only result carries a zero character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !char_valid_o |-> out_char_o == 8'd0)
    else $error("status-only result with nonzero character");

  // A character result always reports ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && char_valid_o |-> status_o == i2p_pkg::STATUS_OK)
    else $error("character result with error status");

  // The end of an expression is also the end of its character's run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && expr_done_o |-> last_of_run_o)
    else $error("expression done without last of run");

endmodule

bind infix_to_postfix_converter i2p_port_checker u_i2p_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .out_char_o    (out_char_o),
  .char_valid_o  (char_valid_o),
  .status_o      (status_o),
  .last_of_run_o (last_of_run_o),
  .expr_done_o   (expr_done_o)
);
